### rtl/core/sam_pkg.sv
// Shared types, constants and codes of the Shift-And string matcher.
// Used by the top, controller and datapath modules; depends on nothing else.
package sam_pkg;

    // Width of one word of a character mask and of the match vector.
    localparam int WORD_W = 64;
    // log2 of the word width: bits of a pattern position that select a bit in its word.
    localparam int WORD_SHIFT = 6;
    localparam int LEN_W = 9;
    localparam int POS_W = 16;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int DEF_PATTERN_WORDS = 4;
    localparam int DEF_ALPHABET_SIZE = 256;
    localparam int DEF_TEXT_INDEX_BITS = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd1;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_TEXT  = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [7:0] pattern_index;
    } in_t;

    typedef struct packed {
        logic               match_found;
        logic [POS_W-1:0]   match_position;
        logic [COUNT_W-1:0] match_count;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted item
        logic clear_all;   // empty mask rows, vector and counters
        logic start;       // restart the word counter, carry and hit flag
        logic cnt_inc;     // advance the word counter
        logic rd_load;     // read the mask word that the load item addresses
        logic rd_next;     // read word counter + 1 instead of the counter
        logic wr_load;     // write back the mask word with the new bit set
        logic wr_fill;     // write one word of a fresh mask row
        logic row_set;     // mark the current character's mask row as written
        logic txt_proc;    // shift, AND and write back one vector word
        logic finish;      // update counters and register the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
        logic is_load;
        logic is_text;
        logic load_ok;
        logic row_valid;
        logic last_word;
        logic out_free;
    } stat_t;

endpackage

### rtl/core/shift_and_matcher_top.sv
// Steps from input transfer to result valid: decode and done for a clear or unused
// request; decode, mask write and done for a load into a written row; decode, fill and
// done for a fresh row; for text, decode, read, one vector word per cycle, then done.
// One item at a time; the next is taken in the cycle after the result is registered.
// Reset: asynchronous, active low; empties masks, vector and counters, length = 1.
module shift_and_matcher_top #(
    parameter int PATTERN_WORDS = sam_pkg::DEF_PATTERN_WORDS,
    parameter int ALPHABET_SIZE = sam_pkg::DEF_ALPHABET_SIZE,
    parameter int TEXT_INDEX_BITS = sam_pkg::DEF_TEXT_INDEX_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sam_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sam_pkg::out_t             out_data,
    input  logic                      cfg_wr_en,
    input  logic [sam_pkg::LEN_W-1:0] cfg_wr_data
);

    sam_pkg::cmd_t  cmd;
    sam_pkg::stat_t stat;

    sam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sam_dpath #(
        .PATTERN_WORDS   (PATTERN_WORDS),
        .ALPHABET_SIZE   (ALPHABET_SIZE),
        .TEXT_INDEX_BITS (TEXT_INDEX_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_data     (in_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule

### rtl/core/sam_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the character masks and the match vector.
module sam_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/sam_ctrl.sv
// Controller of the Shift-And matcher: sequences one item at a time.
// Depends on sam_pkg for the command and status structs.
module sam_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sam_pkg::stat_t stat,
    output sam_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_LWR    = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_TRD    = 3'd4;
    localparam logic [2:0] S_TRUN   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.start = 1'b1;
                if (stat.is_clear)
                begin
                    cmd.clear_all = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.is_load)
                begin
                    if (!stat.load_ok)
                    begin
                        state_next = S_DONE;
                    end
                    else if (stat.row_valid)
                    begin
                        cmd.rd_load = 1'b1;
                        state_next = S_LWR;
                    end
                    else
                    begin
                        state_next = S_FILL;
                    end
                end
                else if (stat.is_text)
                begin
                    state_next = S_TRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LWR:
            begin
                cmd.wr_load = 1'b1;
                state_next = S_DONE;
            end
            S_FILL:
            begin
                cmd.wr_fill = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.last_word)
                begin
                    cmd.row_set = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_TRD:
            begin
                // The first vector and mask words are read here.
                state_next = S_TRUN;
            end
            S_TRUN:
            begin
                cmd.txt_proc = 1'b1;
                cmd.rd_next = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.last_word)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/sam_dpath.sv
// Datapath of the Shift-And matcher: mask and vector RAMs, row and word
// valid bits, counters and the result register. Depends on sam_pkg, sam_ram.
module sam_dpath #(
    parameter int PATTERN_WORDS = sam_pkg::DEF_PATTERN_WORDS,
    parameter int ALPHABET_SIZE = sam_pkg::DEF_ALPHABET_SIZE,
    parameter int TEXT_INDEX_BITS = sam_pkg::DEF_TEXT_INDEX_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sam_pkg::cmd_t              cmd,
    output sam_pkg::stat_t             stat,
    input  sam_pkg::in_t               in_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output sam_pkg::out_t              out_data,
    input  logic                       cfg_wr_en,
    input  logic [sam_pkg::LEN_W-1:0]  cfg_wr_data
);

    localparam int WW = sam_pkg::WORD_W;
    localparam int WAW = (PATTERN_WORDS > 1) ? $clog2(PATTERN_WORDS) : 1;
    localparam int CB = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int ROWS = 2 ** CB;
    localparam int MASK_AW = WAW + CB;
    localparam int MASK_DEPTH = 2 ** MASK_AW;
    localparam int CAPACITY = PATTERN_WORDS * WW;
    localparam int TIB = TEXT_INDEX_BITS;
    localparam int OW = (TIB > sam_pkg::POS_W) ? TIB : sam_pkg::POS_W;
    localparam int CW = 16;

    sam_pkg::in_t item_reg;
    logic [sam_pkg::LEN_W-1:0] len_reg;
    logic [ROWS-1:0] row_valid_reg;
    logic [2**WAW-1:0] vec_valid_reg;
    logic [WAW-1:0] cnt_reg;
    logic carry_reg;
    logic hit_reg;
    logic vv_rd_reg;
    logic [TIB-1:0] text_index_reg;
    logic [sam_pkg::COUNT_W-1:0] found_reg;
    logic out_valid_reg;
    sam_pkg::out_t out_reg;

    logic [CB-1:0] ch;
    logic ch_ok;
    logic load_ok;
    logic [WAW-1:0] load_word;
    logic [WW-1:0] load_bit;
    logic row_ok;
    logic [WAW-1:0] rd_word;
    logic [WW-1:0] mask_rdata;
    logic [WW-1:0] vec_rdata;
    logic mask_we;
    logic [WAW-1:0] mask_wword;
    logic [WW-1:0] mask_wdata;
    logic [WW-1:0] old_word;
    logic [WW-1:0] mask_word;
    logic [WW-1:0] new_word;
    logic [sam_pkg::LEN_W-1:0] top;
    logic len_ok;
    logic is_top_word;
    logic match;
    logic [sam_pkg::COUNT_W-1:0] found_next;
    logic [TIB-1:0] start_pos;
    logic [OW-1:0] start_wide;

    assign ch = item_reg.char_code[CB-1:0];
    assign ch_ok = ({1'b0, item_reg.char_code} < 9'(ALPHABET_SIZE));
    assign load_ok = ch_ok && (CW'(item_reg.pattern_index) < CW'(CAPACITY));
    assign load_word = WAW'(item_reg.pattern_index[7:sam_pkg::WORD_SHIFT]);
    assign load_bit = WW'(1) << item_reg.pattern_index[sam_pkg::WORD_SHIFT-1:0];
    assign row_ok = ch_ok && row_valid_reg[ch];

    assign stat.is_clear = (item_reg.req_type == sam_pkg::REQ_CLEAR);
    assign stat.is_load = (item_reg.req_type == sam_pkg::REQ_LOAD);
    assign stat.is_text = (item_reg.req_type == sam_pkg::REQ_TEXT);
    assign stat.load_ok = load_ok;
    assign stat.row_valid = row_ok;
    assign stat.last_word = (cnt_reg == WAW'(PATTERN_WORDS - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    // Read address: the load word, the next word while streaming, else the counter.
    always_comb
    begin
        if (cmd.rd_next)
        begin
            rd_word = cnt_reg + WAW'(1);
        end
        else if (cmd.rd_load)
        begin
            rd_word = load_word;
        end
        else
        begin
            rd_word = cnt_reg;
        end
    end

    assign mask_we = cmd.wr_load || cmd.wr_fill;
    assign mask_wword = cmd.wr_load ? load_word : cnt_reg;

    always_comb
    begin
        if (cmd.wr_load)
        begin
            mask_wdata = mask_rdata | load_bit;
        end
        else if (cnt_reg == load_word)
        begin
            mask_wdata = load_bit;
        end
        else
        begin
            mask_wdata = '0;
        end
    end

    sam_ram #(
        .WIDTH (WW),
        .DEPTH (MASK_DEPTH),
        .AW    (MASK_AW)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr ({mask_wword, ch}),
        .wdata (mask_wdata),
        .raddr ({rd_word, ch}),
        .rdata (mask_rdata)
    );

    // Words never written since the last clear read as zero.
    assign old_word = vv_rd_reg ? vec_rdata : '0;
    assign mask_word = row_ok ? mask_rdata : '0;
    assign new_word = {old_word[WW-2:0], carry_reg} & mask_word;

    sam_ram #(
        .WIDTH (WW),
        .DEPTH (PATTERN_WORDS),
        .AW    (WAW)
    ) u_vec_ram (
        .clk   (clk),
        .we    (cmd.txt_proc),
        .waddr (cnt_reg),
        .wdata (new_word),
        .raddr (rd_word),
        .rdata (vec_rdata)
    );

    assign top = len_reg - sam_pkg::LEN_W'(1);
    assign len_ok = (len_reg != '0) && (CW'(len_reg) <= CW'(CAPACITY));
    assign is_top_word =
        (CW'(cnt_reg) == CW'(top[sam_pkg::LEN_W-1:sam_pkg::WORD_SHIFT]));

    assign match = stat.is_text && len_ok && hit_reg;
    assign found_next = (match && (found_reg != sam_pkg::COUNT_MAX)) ?
                        found_reg + sam_pkg::COUNT_W'(1) : found_reg;
    assign start_pos = text_index_reg - TIB'(len_reg) + TIB'(1);
    assign start_wide = OW'(start_pos);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        vv_rd_reg <= vec_valid_reg[rd_word];
        if (cmd.start)
        begin
            cnt_reg <= '0;
            carry_reg <= 1'b1;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + WAW'(1);
            end
            if (cmd.txt_proc)
            begin
                carry_reg <= old_word[WW-1];
                if (is_top_word)
                begin
                    hit_reg <= new_word[top[sam_pkg::WORD_SHIFT-1:0]];
                end
            end
        end
        if (cmd.finish)
        begin
            out_reg.match_found <= match;
            out_reg.match_position <= match ? start_wide[sam_pkg::POS_W-1:0] : '0;
            out_reg.match_count <= found_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= sam_pkg::LEN_RESET;
            row_valid_reg <= '0;
            vec_valid_reg <= '0;
            text_index_reg <= '0;
            found_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (cmd.clear_all)
            begin
                row_valid_reg <= '0;
                vec_valid_reg <= '0;
                text_index_reg <= '0;
                found_reg <= '0;
            end
            if (cmd.row_set)
            begin
                row_valid_reg[ch] <= 1'b1;
            end
            if (cmd.txt_proc)
            begin
                vec_valid_reg[cnt_reg] <= 1'b1;
            end
            if (cmd.finish)
            begin
                found_reg <= found_next;
                if (stat.is_text)
                begin
                    text_index_reg <= text_index_reg + TIB'(1);
                end
                // A match empties the vector so that matches never overlap.
                if (match)
                begin
                    vec_valid_reg <= '0;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule
